// ----- hdl/otcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcs_pkg
// Shared widths, codes, defaults and configuration types of the temperature
// channel sequencer.
// ----------------------------------------------------------------------------
package otcs_pkg;

  localparam int CH_W       = 2;
  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 16;
  localparam int TEMP_W     = 18;
  localparam int MASK_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 18;

  localparam int OVERSAMPLE_DEF   = 16;
  localparam int BUSY_RETRIES_DEF = 10;
  localparam int NUM_CHANNELS_DEF = 3;

  // q8 degrees per count: 1000 mdeg scale over a 1024 step, times 256
  localparam int MDEG_PER_DEG = 1000;
  localparam int ADC_FULL     = 1024;
  localparam int Q8_ONE       = 256;
  localparam int TC_SCALE     = MDEG_PER_DEG * Q8_ONE / ADC_FULL;

  localparam logic [MASK_W-1:0] MASK_RESET     = '0;
  localparam logic [TEMP_W-1:0] MAX_TEMP_RESET = 18'd66560;
  localparam logic [SUM_W-1:0]  TC_OPEN_RESET  = 16'hFFFF;
  localparam logic [SUM_W-1:0]  TH_OPEN_RESET  = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MASK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TC_OPEN     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TH_OPEN     = 8'd3;

  typedef enum logic [1:0] {
    KIND_ACCUM = 2'd0,
    KIND_READY = 2'd1,
    KIND_BUSY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_READ  = 2'd1,
    ST_UNPLUGGED = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef struct packed {
    logic [MASK_W-1:0] sensor_type_mask;
    logic [TEMP_W-1:0] max_temp_q8;
    logic [SUM_W-1:0]  tc_open_limit;
    logic [SUM_W-1:0]  thermistor_open_limit;
  } cfg_t;

endpackage

// ----- hdl/otcs_convert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcs_convert
// Turns a finished oversampled sum into a q8 temperature and a sensor status.
// ----------------------------------------------------------------------------
module otcs_convert #(
  parameter int OVERSAMPLE = otcs_pkg::OVERSAMPLE_DEF
) (
  input  logic [otcs_pkg::SUM_W-1:0]  sum,
  input  logic                        is_tc,
  input  otcs_pkg::cfg_t              cfg,
  output logic [otcs_pkg::TEMP_W-1:0] temp,
  output otcs_pkg::status_t           status
);

  // floor(sum * TC_SCALE / OVERSAMPLE) via a rounded-up reciprocal, exact below 2^24
  localparam int    RECIP_SHIFT = 30;
  localparam longint RECIP      = ((64'd1 << RECIP_SHIFT) + OVERSAMPLE - 1) / OVERSAMPLE;
  localparam longint TC_MULT    = RECIP * otcs_pkg::TC_SCALE;
  localparam int    MULT_W      = $clog2(TC_MULT + 1);
  localparam int    PROD_W      = otcs_pkg::SUM_W + MULT_W;
  localparam int    QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [MULT_W-1:0] TC_MULT_C = MULT_W'(TC_MULT);

  logic [PROD_W-1:0] product;
  logic [QUOT_W-1:0] quot;

  assign product = PROD_W'(sum) * PROD_W'(TC_MULT_C);
  assign quot    = product[PROD_W-1:RECIP_SHIFT];

  always_comb begin
    temp   = '0;
    status = otcs_pkg::ST_OK;
    if (is_tc) begin
      if (sum >= cfg.tc_open_limit) begin
        temp   = cfg.max_temp_q8;
        status = otcs_pkg::ST_UNPLUGGED;
      end else begin
        temp = quot[otcs_pkg::TEMP_W-1:0];
        // scaled >= max*N is the same test as floor(scaled/N) >= max
        if (quot >= QUOT_W'(cfg.max_temp_q8)) begin
          status = otcs_pkg::ST_BAD_READ;
        end
      end
    end else if (sum >= cfg.thermistor_open_limit) begin
      temp   = cfg.max_temp_q8;
      status = otcs_pkg::ST_UNPLUGGED;
    end
  end

endmodule

// ----- hdl/oversampled_temp_channel_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oversampled_temp_channel_sequencer_core
// Round-robin oversampling sequencer for temperature converter channels.
// ----------------------------------------------------------------------------
// Each poll transaction carries a converter-done flag and a sample and gives
// exactly one result transaction. A poll is taken in every cycle in which the
// result register is empty or being emptied, so the block sustains one poll
// per clock unless out_ready stalls it; the result is registered. The per-poll
// path is the sum update, one constant multiply for the thermocouple scaling
// and the limit compares, all ahead of the result register. Configuration
// writes are always ready and apply from the next poll on.
module oversampled_temp_channel_sequencer_core #(
  parameter int OVERSAMPLE   = otcs_pkg::OVERSAMPLE_DEF,
  parameter int BUSY_RETRIES = otcs_pkg::BUSY_RETRIES_DEF,
  parameter int NUM_CHANNELS = otcs_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [otcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [otcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            adc_done,
  input  logic [otcs_pkg::SAMPLE_W-1:0]   adc_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      result_kind,
  output logic [otcs_pkg::CH_W-1:0]       done_channel,
  output logic [otcs_pkg::TEMP_W-1:0]     temperature_q8,
  output logic [otcs_pkg::SUM_W-1:0]      reading_sum,
  output logic                            is_thermocouple,
  output logic [1:0]                      sensor_status,
  output logic [otcs_pkg::CH_W-1:0]       start_channel
);

  localparam int CNT_W  = $clog2(OVERSAMPLE + 1);
  localparam int BUSY_W = $clog2(BUSY_RETRIES + 1);

  localparam logic [otcs_pkg::CH_W-1:0] CH_BED   = otcs_pkg::CH_W'(NUM_CHANNELS - 1);
  localparam logic [otcs_pkg::CH_W-1:0] CH_FIRST = otcs_pkg::CH_W'(NUM_CHANNELS - 2);
  localparam logic [CNT_W-1:0]          CNT_END  = CNT_W'(OVERSAMPLE);
  localparam logic [BUSY_W-1:0]         BUSY_END = BUSY_W'(BUSY_RETRIES);

  otcs_pkg::cfg_t cfg;

  logic [otcs_pkg::CH_W-1:0]  channel,       channel_next;
  logic [otcs_pkg::CH_W-1:0]  last_channel,  last_channel_next;
  logic [CNT_W-1:0]           sample_count,  sample_count_next;
  logic [otcs_pkg::SUM_W-1:0] running_sum,   running_sum_next;
  logic [BUSY_W-1:0]          busy_attempts, busy_attempts_next;
  otcs_pkg::status_t          status_reg,    status_reg_next;

  logic [otcs_pkg::SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]            cnt_inc;
  logic [BUSY_W-1:0]           busy_inc;
  logic [otcs_pkg::CH_W-1:0]   chan_adv;
  logic                        chan_tc;
  logic [otcs_pkg::TEMP_W-1:0] conv_temp;
  otcs_pkg::status_t           conv_status;

  otcs_pkg::kind_t             kind;
  logic [otcs_pkg::TEMP_W-1:0] temp_res;
  logic [otcs_pkg::SUM_W-1:0]  sum_res;
  logic                        tc_res;

  logic in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_acc    = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_type_mask      <= otcs_pkg::MASK_RESET;
      cfg.max_temp_q8           <= otcs_pkg::MAX_TEMP_RESET;
      cfg.tc_open_limit         <= otcs_pkg::TC_OPEN_RESET;
      cfg.thermistor_open_limit <= otcs_pkg::TH_OPEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        otcs_pkg::CFG_SENSOR_MASK: begin
          cfg.sensor_type_mask <= cfg_data[otcs_pkg::MASK_W-1:0];
        end
        otcs_pkg::CFG_MAX_TEMP: begin
          cfg.max_temp_q8 <= cfg_data[otcs_pkg::TEMP_W-1:0];
        end
        otcs_pkg::CFG_TC_OPEN: begin
          cfg.tc_open_limit <= cfg_data[otcs_pkg::SUM_W-1:0];
        end
        otcs_pkg::CFG_TH_OPEN: begin
          cfg.thermistor_open_limit <= cfg_data[otcs_pkg::SUM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign sum_acc  = running_sum + otcs_pkg::SUM_W'(adc_sample);
  assign cnt_inc  = sample_count + CNT_W'(1);
  assign busy_inc = busy_attempts + BUSY_W'(1);
  assign chan_adv = (channel == CH_BED) ? '0 : channel + otcs_pkg::CH_W'(1);
  assign chan_tc  = (channel < otcs_pkg::CH_W'(2)) && (channel != CH_BED) &&
                    cfg.sensor_type_mask[channel[0]];

  otcs_convert #(
    .OVERSAMPLE(OVERSAMPLE)
  ) u_convert (
    .sum    (sum_acc),
    .is_tc  (chan_tc),
    .cfg    (cfg),
    .temp   (conv_temp),
    .status (conv_status)
  );

  always_comb begin
    channel_next       = channel;
    last_channel_next  = last_channel;
    sample_count_next  = sample_count;
    running_sum_next   = running_sum;
    busy_attempts_next = busy_attempts;
    status_reg_next    = status_reg;
    kind               = otcs_pkg::KIND_ACCUM;
    temp_res           = '0;
    sum_res            = '0;
    tc_res             = 1'b0;
    if (!adc_done) begin
      kind               = otcs_pkg::KIND_BUSY;
      status_reg_next    = otcs_pkg::ST_BUSY;
      busy_attempts_next = busy_inc;
      if (busy_inc == BUSY_END) begin
        // skip the channel after too many busy polls
        last_channel_next  = channel;
        running_sum_next   = '0;
        sample_count_next  = '0;
        channel_next       = chan_adv;
        busy_attempts_next = '0;
      end
    end else begin
      busy_attempts_next = '0;
      running_sum_next   = sum_acc;
      sample_count_next  = cnt_inc;
      if (cnt_inc == CNT_END) begin
        kind              = otcs_pkg::KIND_READY;
        sum_res           = sum_acc;
        tc_res            = chan_tc;
        temp_res          = conv_temp;
        status_reg_next   = conv_status;
        last_channel_next = channel;
        running_sum_next  = '0;
        sample_count_next = '0;
        channel_next      = chan_adv;
      end
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel       <= CH_BED;
      last_channel  <= CH_FIRST;
      sample_count  <= '0;
      running_sum   <= '0;
      busy_attempts <= '0;
      status_reg    <= otcs_pkg::ST_OK;
    end else if (in_acc) begin
      channel       <= channel_next;
      last_channel  <= last_channel_next;
      sample_count  <= sample_count_next;
      running_sum   <= running_sum_next;
      busy_attempts <= busy_attempts_next;
      status_reg    <= status_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      result_kind     <= kind;
      done_channel    <= last_channel_next;
      temperature_q8  <= temp_res;
      reading_sum     <= sum_res;
      is_thermocouple <= tc_res;
      sensor_status   <= status_reg_next;
      start_channel   <= channel_next;
    end
  end

`ifndef SYNTHESIS
  a_busy_poll_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && !adc_done |=> out_valid && result_kind == otcs_pkg::KIND_BUSY &&
      sensor_status == otcs_pkg::ST_BUSY)
    else $error("busy poll did not give a busy result");

  a_idle_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != otcs_pkg::KIND_READY |->
      reading_sum == '0 && !is_thermocouple && temperature_q8 == '0)
    else $error("non-ready result carries reading data");

  a_tc_not_bed: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_thermocouple |-> done_channel != CH_BED)
    else $error("bed channel reported as thermocouple");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count < CNT_END && busy_attempts < BUSY_END)
    else $error("sample or busy count out of range");

  a_ready_advances: assert property (@(posedge clk) disable iff (rst)
    in_acc && kind == otcs_pkg::KIND_READY |=> sample_count == '0 && running_sum == '0)
    else $error("finished channel left accumulator state behind");
`endif

endmodule

// ----- tb/tb_oversampled_temp_channel_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oversampled_temp_channel_sequencer_core
// Checks every result transaction of the temperature channel sequencer
// against an in-bench model of the channel, sum, busy-retry and status
// state. A short directed plan covers reset values, busy retries, channel
// skip and a thermocouple over-limit reading. Phases of random polls
// follow, each under new register settings, with random stalls on both
// sides in all phases but one, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_oversampled_temp_channel_sequencer_core;

  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_POLLS    = 95;
  localparam int IDLE_PCT       = 16;
  localparam int PRINT_LIMIT    = 40;
  localparam int Q8_PER_COUNT   = 1000 * 256 / 1024;
  localparam int BED_CHANNEL    = otcs_pkg::NUM_CHANNELS_DEF - 1;
  localparam logic [otcs_pkg::CFG_IDX_W-1:0] CFG_NO_REG = '1;
  localparam logic [otcs_pkg::SAMPLE_W-1:0]  SAMPLE_MAX = '1;

  typedef struct packed {
    otcs_pkg::kind_t             kind;
    logic [otcs_pkg::CH_W-1:0]   done_ch;
    logic [otcs_pkg::TEMP_W-1:0] temp;
    logic [otcs_pkg::SUM_W-1:0]  sum;
    logic                        tc;
    otcs_pkg::status_t           status;
    logic [otcs_pkg::CH_W-1:0]   next_ch;
  } reading_t;

  typedef enum logic {ROW_POLL, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t                               op;
    int                                    reps;
    logic                                  done;
    logic [otcs_pkg::SAMPLE_W-1:0]         sample;
    logic [otcs_pkg::CFG_IDX_W-1:0]        reg_idx;
    logic [otcs_pkg::CFG_DATA_W-1:0]       reg_val;
    logic                                  fixed;
    reading_t                              want;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [otcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [otcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            adc_done = 1'b0;
  logic [otcs_pkg::SAMPLE_W-1:0]   adc_sample = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      result_kind;
  logic [otcs_pkg::CH_W-1:0]       done_channel;
  logic [otcs_pkg::TEMP_W-1:0]     temperature_q8;
  logic [otcs_pkg::SUM_W-1:0]      reading_sum;
  logic                            is_thermocouple;
  logic [1:0]                      sensor_status;
  logic [otcs_pkg::CH_W-1:0]       start_channel;

  // sequencer model state
  otcs_pkg::cfg_t             seq_cfg;
  logic [otcs_pkg::CH_W-1:0]  seq_ch;
  logic [otcs_pkg::CH_W-1:0]  seq_last;
  logic [6:0]                 seq_count;
  logic [otcs_pkg::SUM_W-1:0] seq_sum;
  logic [3:0]                 seq_busy;
  otcs_pkg::status_t          seq_status;

  reading_t expected_readings[$];
  reading_t pinned_reading = '0;
  logic     pinned_fixed = 1'b0;
  int       mismatches = 0;
  int       stall_cycles = 0;
  int       idle_pct = IDLE_PCT;
  logic     hold_req = 1'b0;
  plan_row_t directed_plan[9];

  oversampled_temp_channel_sequencer_core uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .adc_done        (adc_done),
    .adc_sample      (adc_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .done_channel    (done_channel),
    .temperature_q8  (temperature_q8),
    .reading_sum     (reading_sum),
    .is_thermocouple (is_thermocouple),
    .sensor_status   (sensor_status),
    .start_channel   (start_channel)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void close_channel();
    seq_last  = seq_ch;
    seq_sum   = '0;
    seq_count = '0;
    seq_ch    = (seq_ch + 1 >= otcs_pkg::NUM_CHANNELS_DEF) ? '0 : seq_ch + 1'b1;
  endfunction

  task automatic advance_sequencer(input logic done,
                                   input logic [otcs_pkg::SAMPLE_W-1:0] sample,
                                   output reading_t r);
    logic [31:0]                scaled;
    logic [otcs_pkg::SUM_W-1:0] open_limit;
    logic                       tc_ch;
    r = '0;
    if (!done) begin
      seq_status = otcs_pkg::ST_BUSY;
      if (seq_busy != 4'hF) seq_busy = seq_busy + 4'd1;
      if (seq_busy >= otcs_pkg::BUSY_RETRIES_DEF) begin
        close_channel();
        seq_busy = '0;
      end
      r.kind = otcs_pkg::KIND_BUSY;
    end else begin
      seq_busy  = '0;
      seq_sum   = seq_sum + otcs_pkg::SUM_W'(sample);
      seq_count = seq_count + 7'd1;
      if (seq_count >= otcs_pkg::OVERSAMPLE_DEF) begin
        tc_ch = (seq_ch < 2 && seq_ch != BED_CHANNEL) ?
                seq_cfg.sensor_type_mask[seq_ch[0]] : 1'b0;
        open_limit = tc_ch ? seq_cfg.tc_open_limit : seq_cfg.thermistor_open_limit;
        r.sum = seq_sum;
        r.tc  = tc_ch;
        if (seq_sum >= open_limit) begin
          r.temp     = seq_cfg.max_temp_q8;
          seq_status = otcs_pkg::ST_UNPLUGGED;
        end else if (tc_ch) begin
          scaled     = 32'(seq_sum) * Q8_PER_COUNT;
          r.temp     = otcs_pkg::TEMP_W'(scaled / otcs_pkg::OVERSAMPLE_DEF);
          seq_status = (scaled < 32'(seq_cfg.max_temp_q8) * otcs_pkg::OVERSAMPLE_DEF) ?
                       otcs_pkg::ST_OK : otcs_pkg::ST_BAD_READ;
        end else begin
          seq_status = otcs_pkg::ST_OK;
        end
        close_channel();
        r.kind = otcs_pkg::KIND_READY;
      end else begin
        r.kind = otcs_pkg::KIND_ACCUM;
      end
    end
    r.done_ch = seq_last;
    r.status  = seq_status;
    r.next_ch = seq_ch;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // predictor, result checking and watchdog
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    reading_t predicted;
    if (rst) begin
      seq_cfg    = '{otcs_pkg::MASK_RESET, otcs_pkg::MAX_TEMP_RESET,
                     otcs_pkg::TC_OPEN_RESET, otcs_pkg::TH_OPEN_RESET};
      seq_ch     = otcs_pkg::CH_W'(BED_CHANNEL);
      seq_last   = otcs_pkg::CH_W'(BED_CHANNEL - 1);
      seq_count  = '0;
      seq_sum    = '0;
      seq_busy   = '0;
      seq_status = otcs_pkg::ST_OK;
      stall_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{otcs_pkg::kind_t'(result_kind), done_channel, temperature_q8, reading_sum,
                is_thermocouple, otcs_pkg::status_t'(sensor_status), start_channel};
        if (expected_readings.size() == 0) begin
          report_mismatch("transaction with nothing expected", result_kind, 0);
        end else begin
          want = expected_readings.pop_front();
          if (got.kind !== want.kind) report_mismatch("result_kind", got.kind, want.kind);
          if (got.done_ch !== want.done_ch)
            report_mismatch("done_channel", got.done_ch, want.done_ch);
          if (got.temp !== want.temp) report_mismatch("temperature_q8", got.temp, want.temp);
          if (got.sum !== want.sum) report_mismatch("reading_sum", got.sum, want.sum);
          if (got.tc !== want.tc) report_mismatch("is_thermocouple", got.tc, want.tc);
          if (got.status !== want.status)
            report_mismatch("sensor_status", got.status, want.status);
          if (got.next_ch !== want.next_ch)
            report_mismatch("start_channel", got.next_ch, want.next_ch);
        end
      end
      if (in_valid && in_ready) begin
        advance_sequencer(adc_done, adc_sample, predicted);
        expected_readings.push_back(pinned_fixed ? pinned_reading : predicted);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          otcs_pkg::CFG_SENSOR_MASK:
            seq_cfg.sensor_type_mask = cfg_data[otcs_pkg::MASK_W-1:0];
          otcs_pkg::CFG_MAX_TEMP:
            seq_cfg.max_temp_q8 = cfg_data[otcs_pkg::TEMP_W-1:0];
          otcs_pkg::CFG_TC_OPEN:
            seq_cfg.tc_open_limit = cfg_data[otcs_pkg::SUM_W-1:0];
          otcs_pkg::CFG_TH_OPEN:
            seq_cfg.thermistor_open_limit = cfg_data[otcs_pkg::SUM_W-1:0];
          default: ;
        endcase
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_poll(input logic done, input logic [otcs_pkg::SAMPLE_W-1:0] sample,
                           input logic fixed, input reading_t want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    adc_done       = done;
    adc_sample     = sample;
    pinned_fixed   = fixed;
    pinned_reading = want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_register(input logic [otcs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [otcs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int                            phase;
    int                            n;
    int                            roll;
    logic [otcs_pkg::SAMPLE_W-1:0] lo;
    logic [otcs_pkg::SAMPLE_W-1:0] hi;
    logic [otcs_pkg::MASK_W-1:0]   mask;
    logic [otcs_pkg::TEMP_W-1:0]   temp_limit;
    logic [otcs_pkg::SUM_W-1:0]    tc_open;
    logic [otcs_pkg::SUM_W-1:0]    th_open;

    directed_plan[0] = '{ROW_POLL, 1, 1'b1, '0, '0, '0, 1'b1,
                         '{otcs_pkg::KIND_ACCUM, 2'd1, '0, '0, 1'b0,
                           otcs_pkg::ST_OK, 2'd2}};
    directed_plan[1] = '{ROW_POLL, 1, 1'b0, SAMPLE_MAX, '0, '0, 1'b1,
                         '{otcs_pkg::KIND_BUSY, 2'd1, '0, '0, 1'b0,
                           otcs_pkg::ST_BUSY, 2'd2}};
    directed_plan[2] = '{ROW_POLL, 1, 1'b1, SAMPLE_MAX, '0, '0, 1'b1,
                         '{otcs_pkg::KIND_ACCUM, 2'd1, '0, '0, 1'b0,
                           otcs_pkg::ST_BUSY, 2'd2}};
    directed_plan[3] = '{ROW_POLL, otcs_pkg::BUSY_RETRIES_DEF - 1, 1'b0, '0, '0, '0, 1'b0,
                         '0};
    directed_plan[4] = '{ROW_POLL, 1, 1'b0, '0, '0, '0, 1'b1,
                         '{otcs_pkg::KIND_BUSY, 2'd2, '0, '0, 1'b0,
                           otcs_pkg::ST_BUSY, 2'd0}};
    directed_plan[5] = '{ROW_CFG, 0, 1'b0, '0, otcs_pkg::CFG_SENSOR_MASK, 18'h3FFFD, 1'b0,
                         '0};
    directed_plan[6] = '{ROW_CFG, 0, 1'b0, '0, CFG_NO_REG, '1, 1'b0, '0};
    directed_plan[7] = '{ROW_POLL, otcs_pkg::OVERSAMPLE_DEF - 1, 1'b1, SAMPLE_MAX, '0, '0,
                         1'b0, '0};
    directed_plan[8] = '{ROW_POLL, 1, 1'b1, SAMPLE_MAX, '0, '0, 1'b1,
                         '{otcs_pkg::KIND_READY, 2'd0, 18'd255750, 16'd16368, 1'b1,
                           otcs_pkg::ST_BAD_READ, 2'd1}};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].op == ROW_CFG) begin
        write_register(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        for (n = 0; n < directed_plan[i].reps; n++)
          send_poll(directed_plan[i].done, directed_plan[i].sample,
                    directed_plan[i].fixed && n == directed_plan[i].reps - 1,
                    directed_plan[i].want);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          mask = '0; temp_limit = '0; tc_open = '0; th_open = '0;
        end
        1: begin
          mask = '1; temp_limit = '1; tc_open = '1; th_open = '1;
        end
        default: begin
          mask       = otcs_pkg::MASK_W'($urandom_range(3));
          temp_limit = otcs_pkg::TEMP_W'($urandom_range(262143));
          tc_open    = ($urandom_range(9) == 0) ? '1 : otcs_pkg::SUM_W'($urandom_range(16383));
          th_open    = ($urandom_range(9) == 0) ? '1 : otcs_pkg::SUM_W'($urandom_range(16383));
        end
      endcase
      write_register(otcs_pkg::CFG_SENSOR_MASK, {16'($urandom), mask});
      write_register(otcs_pkg::CFG_MAX_TEMP, temp_limit);
      write_register(otcs_pkg::CFG_TC_OPEN, {2'($urandom), tc_open});
      write_register(otcs_pkg::CFG_TH_OPEN, {2'($urandom), th_open});
      if (phase % 2 == 1)
        write_register(otcs_pkg::CFG_IDX_W'(otcs_pkg::CFG_TH_OPEN + 1 + $urandom_range(250)),
                       otcs_pkg::CFG_DATA_W'($urandom));

      idle_pct = (phase == 4) ? 0 : IDLE_PCT;
      if (phase == 7) hold_req = 1'b1;

      lo = otcs_pkg::SAMPLE_W'($urandom_range(1023));
      hi = otcs_pkg::SAMPLE_W'($urandom_range(1023, lo));
      n = 0;
      while (n < PHASE_POLLS) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          repeat (otcs_pkg::BUSY_RETRIES_DEF)
            send_poll(1'b0, otcs_pkg::SAMPLE_W'($urandom), 1'b0, '0);
          n += otcs_pkg::BUSY_RETRIES_DEF;
        end else begin
          if (roll < 14)
            send_poll(1'b0, otcs_pkg::SAMPLE_W'($urandom), 1'b0, '0);
          else if (roll < 20)
            send_poll(1'b1, $urandom_range(1) ? SAMPLE_MAX : '0, 1'b0, '0);
          else
            send_poll(1'b1, otcs_pkg::SAMPLE_W'($urandom_range(hi, lo)), 1'b0, '0);
          n++;
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/otcs_pkg.sv
hdl/otcs_convert.sv
hdl/oversampled_temp_channel_sequencer_core.sv
tb/tb_oversampled_temp_channel_sequencer_core.sv
